>>> sv/qpp_pkg.sv
package qpp_pkg;

    localparam logic [3:0] LEN_SHORT = 4'd7;
    localparam logic [3:0] LEN_LONG  = 4'd8;
    localparam logic [3:0] COUNT_MAX = 4'd15;
    localparam logic [7:0] PCT_FULL  = 8'd100;
    localparam logic [7:0] PCT_UNKNOWN = 8'hFF;

    localparam logic [3:0] POS_MAGIC  = 4'd0;
    localparam logic [3:0] POS_USED   = 4'd1;
    localparam logic [3:0] POS_TIME0  = 4'd2;
    localparam logic [3:0] POS_TIME1  = 4'd3;
    localparam logic [3:0] POS_TIME2  = 4'd4;
    localparam logic [3:0] POS_TIME3  = 4'd5;
    localparam logic [3:0] POS_SECOND = 4'd6;

    localparam logic REG_MAGIC_BYTE   = 1'b0;
    localparam logic REG_UNKNOWN_CODE = 1'b1;

    localparam logic [7:0] MAGIC_RESET   = 8'd0;
    localparam logic [7:0] UNKNOWN_RESET = 8'd255;

endpackage

>>> sv/quota_packet_parser.sv
// a result is registered and is on the m_ port in the cycle after the transfer of the last byte
// throughput: one byte per cycle; while a result waits with m_ready low, s_ready is low
// for every byte, not just a last one, since s_ready = !m_valid || m_ready
// the judgment is done in the accept cycle and lands in the result register
// reset (aresetn low, synchronous) clears the packet state and the result valid,
// magic_byte goes to 0 and unknown_code to 255
module quota_packet_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_packet_ok,
    output logic signed [7:0]  m_pct_left,
    output logic signed [7:0]  m_second_pct_left,
    output logic [31:0]        m_reset_time
);

    logic [7:0]  magic_reg;
    logic [7:0]  unknown_reg;

    logic [3:0]  count_reg,  count_next;
    logic [7:0]  xor_reg,    xor_next;
    logic [7:0]  first_reg,  first_next;
    logic [7:0]  used_reg,   used_next;
    logic [31:0] time_reg,   time_next;
    logic [7:0]  second_reg, second_next;

    logic        m_valid_reg;
    logic        ok_reg,   ok_next;
    logic [7:0]  rem_reg,  rem_next;
    logic [7:0]  rem2_reg, rem2_next;
    logic [31:0] when_reg, when_next;

    logic        s_xfer;
    logic        m_xfer;
    logic        base_ok;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid_reg && m_ready;

    // capture by position
    always_comb begin
        first_next  = first_reg;
        used_next   = used_reg;
        time_next   = time_reg;
        second_next = second_reg;
        xor_next    = xor_reg ^ s_data_byte;
        count_next  = (count_reg == qpp_pkg::COUNT_MAX) ? count_reg : count_reg + 4'd1;
        case (count_reg)
            qpp_pkg::POS_MAGIC:  first_next        = s_data_byte;
            qpp_pkg::POS_USED:   used_next         = s_data_byte;
            qpp_pkg::POS_TIME0:  time_next[7:0]    = s_data_byte;
            qpp_pkg::POS_TIME1:  time_next[15:8]   = s_data_byte;
            qpp_pkg::POS_TIME2:  time_next[23:16]  = s_data_byte;
            qpp_pkg::POS_TIME3:  time_next[31:24]  = s_data_byte;
            qpp_pkg::POS_SECOND: second_next       = s_data_byte;
            default: ;
        endcase
    end

    // judgment on the state as it stands after this byte
    always_comb begin
        base_ok = (count_next == qpp_pkg::LEN_SHORT || count_next == qpp_pkg::LEN_LONG)
                  && (xor_next == 8'd0) && (first_next == magic_reg);
        ok_next   = base_ok;
        rem_next  = 8'd0;
        rem2_next = qpp_pkg::PCT_UNKNOWN;
        when_next = 32'd0;
        if (base_ok && count_next == qpp_pkg::LEN_LONG && second_next != unknown_reg) begin
            if (second_next > qpp_pkg::PCT_FULL) begin
                ok_next = 1'b0;
            end else begin
                rem2_next = qpp_pkg::PCT_FULL - second_next;
            end
        end
        if (used_next == unknown_reg) begin
            rem_next = qpp_pkg::PCT_UNKNOWN;
        end else if (used_next > qpp_pkg::PCT_FULL) begin
            ok_next = 1'b0;
        end else begin
            rem_next  = qpp_pkg::PCT_FULL - used_next;
            when_next = time_next;
        end
        if (!ok_next) begin
            rem_next  = 8'd0;
            rem2_next = 8'd0;
            when_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= qpp_pkg::MAGIC_RESET;
            unknown_reg <= qpp_pkg::UNKNOWN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                qpp_pkg::REG_MAGIC_BYTE:   magic_reg   <= cfg_data;
                qpp_pkg::REG_UNKNOWN_CODE: unknown_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 4'd0;
            xor_reg    <= 8'd0;
            first_reg  <= 8'd0;
            used_reg   <= 8'd0;
            time_reg   <= 32'd0;
            second_reg <= 8'd0;
        end else if (s_xfer) begin
            if (s_last_byte) begin
                // packet done, start clean
                count_reg  <= 4'd0;
                xor_reg    <= 8'd0;
                first_reg  <= 8'd0;
                used_reg   <= 8'd0;
                time_reg   <= 32'd0;
                second_reg <= 8'd0;
            end else begin
                count_reg  <= count_next;
                xor_reg    <= xor_next;
                first_reg  <= first_next;
                used_reg   <= used_next;
                time_reg   <= time_next;
                second_reg <= second_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_xfer) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && s_last_byte) begin
            ok_reg   <= ok_next;
            rem_reg  <= rem_next;
            rem2_reg <= rem2_next;
            when_reg <= when_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_packet_ok       = ok_reg;
    assign m_pct_left        = signed'(rem_reg);
    assign m_second_pct_left = signed'(rem2_reg);
    assign m_reset_time      = when_reg;

endmodule

>>> sv/qpp_checker.sv
module qpp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_packet_ok,
    input logic signed [7:0]  m_pct_left,
    input logic signed [7:0]  m_second_pct_left,
    input logic [31:0]        m_reset_time
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_ok)
            && $stable(m_pct_left) && $stable(m_second_pct_left)
            && $stable(m_reset_time))
        else $error("result changed while stalled");

    // failed packets carry all-zero fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_packet_ok |-> m_pct_left == 8'sd0
            && m_second_pct_left == 8'sd0 && m_reset_time == 32'd0)
        else $error("failed packet with nonzero fields");

    // unknown primary percentage has no reset time
    a_unknown_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_ok && m_pct_left == -8'sd1 |-> m_reset_time == 32'd0)
        else $error("reset time reported for unknown percentage");

    // good packets report a percentage in range
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_ok |-> m_pct_left >= -8'sd1 && m_pct_left <= 8'sd100
            && m_second_pct_left >= -8'sd1 && m_second_pct_left <= 8'sd100)
        else $error("percentage out of range");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quota_packet_parser qpp_checker u_qpp_checker (.*);
